// ----- hw/rtl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// shared widths and codes for the circle / segment overlap test
// ----------------------------------------------------------------------------
package csc_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // radius and derived widths
  localparam int RADIUS_BITS = 15;
  localparam int RSUM_BITS   = RADIUS_BITS + 1;
  localparam int RR_BITS     = 2 * RADIUS_BITS;
  localparam int RS2_BITS    = 2 * RSUM_BITS;

  // pair kinds
  localparam logic [1:0] ACT_CIRCLE_CIRCLE   = 2'd0;
  localparam logic [1:0] ACT_CIRCLE_SEGMENT  = 2'd1;
  localparam logic [1:0] ACT_SEGMENT_SEGMENT = 2'd2;

  // both shapes enabled
  localparam logic [1:0] EN_BOTH = 2'b11;

endpackage

// ----- hw/rtl/csc_if.sv -----
// ----------------------------------------------------------------------------
// csc_if
// valid/ready channels for pair items and hit results
// ----------------------------------------------------------------------------
interface csc_in_if #(
  parameter int COORD_BITS = csc_pkg::COORD_BITS_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic [1:0]                         action;
  logic [1:0]                         enable_flags;
  logic signed [COORD_BITS-1:0]       circle_x;
  logic signed [COORD_BITS-1:0]       circle_y;
  logic [csc_pkg::RADIUS_BITS-1:0]    circle_radius;
  logic signed [COORD_BITS-1:0]       base_x;
  logic signed [COORD_BITS-1:0]       base_y;
  logic [csc_pkg::RADIUS_BITS-1:0]    other_radius;
  logic signed [COORD_BITS-1:0]       off0_x;
  logic signed [COORD_BITS-1:0]       off0_y;
  logic signed [COORD_BITS-1:0]       off1_x;
  logic signed [COORD_BITS-1:0]       off1_y;

  modport source (
    output valid, action, enable_flags, circle_x, circle_y, circle_radius,
           base_x, base_y, other_radius, off0_x, off0_y, off1_x, off1_y,
    input  ready
  );
  modport sink (
    input  valid, action, enable_flags, circle_x, circle_y, circle_radius,
           base_x, base_y, other_radius, off0_x, off0_y, off1_x, off1_y,
    output ready
  );
endinterface

interface csc_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ----- hw/rtl/circle_segment_collision_test.sv -----
// ----------------------------------------------------------------------------
// circle_segment_collision_test
// 2d overlap test of a circle against a circle or a segment, one hit bit
// five register stages lie between input transfer and result valid
// throughput: one pair per cycle while results are taken; each stage holds one item and moves on when
//   the stage after it is empty or moving, so bubbles close up under a stall
// reset: rst_n (synchronous, active low) clears all stage valid bits; no state
//   is kept between items
// ----------------------------------------------------------------------------
module circle_segment_collision_test #(
  parameter int COORD_BITS = csc_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  csc_in_if.sink       in_s,
  csc_out_if.source    out_s
);

  // --------------------------------------------------------------------------
  // widths
  // --------------------------------------------------------------------------
  localparam int W   = COORD_BITS;
  localparam int W1  = W + 1;          // circle-circle delta, segment direction
  localparam int W2  = W + 2;          // centre minus segment end
  localparam int PX  = 2 * W1;         // square of a W1 value, signed
  localparam int PC  = W2 + W1;        // cross / dot partial products
  localparam int PQ  = 2 * W2;         // square of a W2 value, signed
  localparam int PD  = PC + 1;         // cross / dot sums
  localparam int H   = W + 1;          // half width of |cross| and of L^2
  localparam int LW  = 2 * H;          // |cross| and L^2 width
  localparam int DW  = 2 * W + 3;      // squared distance to a segment end
  localparam int RRH = csc_pkg::RR_BITS + H;
  localparam int CW  = (4 * H > csc_pkg::RR_BITS + 2 * H) ?
                       4 * H : csc_pkg::RR_BITS + 2 * H;

  // --------------------------------------------------------------------------
  // stage handshake: a stage loads when it is empty or its contents move on
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, out_v_r;
  logic rd1, rd2, rd3, rd4, rd_out;

  assign rd_out = !out_v_r || out_s.ready;
  assign rd4    = !v4_r || rd_out;
  assign rd3    = !v3_r || rd4;
  assign rd2    = !v2_r || rd3;
  assign rd1    = !v1_r || rd2;

  assign in_s.ready  = rd1;
  assign out_s.valid = out_v_r;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_s.valid && in_s.ready;
  assign out_xfer = out_v_r && out_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rd1)    v1_r    <= in_s.valid;
      if (rd2)    v2_r    <= v1_r;
      if (rd3)    v3_r    <= v2_r;
      if (rd4)    v4_r    <= v3_r;
      if (rd_out) out_v_r <= v4_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: pair kind decode and coordinate differences
  // --------------------------------------------------------------------------
  logic                              s1_cc_nxt, s1_seg_nxt;
  logic [csc_pkg::RSUM_BITS-1:0]     s1_rsum_nxt;
  logic signed [W1-1:0]              s1_dx_nxt, s1_dy_nxt, s1_ex_nxt, s1_ey_nxt;
  logic signed [W2-1:0]              s1_c0x_nxt, s1_c0y_nxt, s1_c1x_nxt, s1_c1y_nxt;

  logic                              s1_cc_r, s1_seg_r;
  logic [csc_pkg::RSUM_BITS-1:0]     s1_rsum_r;
  logic [csc_pkg::RADIUS_BITS-1:0]   s1_r_r;
  logic signed [W1-1:0]              s1_dx_r, s1_dy_r, s1_ex_r, s1_ey_r;
  logic signed [W2-1:0]              s1_c0x_r, s1_c0y_r, s1_c1x_r, s1_c1y_r;

  always_comb begin
    // a disabled shape or a kind with no test gives no hit
    s1_cc_nxt   = (in_s.enable_flags == csc_pkg::EN_BOTH) &&
                  (in_s.action == csc_pkg::ACT_CIRCLE_CIRCLE);
    s1_seg_nxt  = (in_s.enable_flags == csc_pkg::EN_BOTH) &&
                  (in_s.action == csc_pkg::ACT_CIRCLE_SEGMENT);
    s1_rsum_nxt = csc_pkg::RSUM_BITS'(in_s.circle_radius) +
                  csc_pkg::RSUM_BITS'(in_s.other_radius);
    // centre to centre
    s1_dx_nxt   = W1'(in_s.circle_x) - W1'(in_s.base_x);
    s1_dy_nxt   = W1'(in_s.circle_y) - W1'(in_s.base_y);
    // segment direction, the base cancels
    s1_ex_nxt   = W1'(in_s.off1_x) - W1'(in_s.off0_x);
    s1_ey_nxt   = W1'(in_s.off1_y) - W1'(in_s.off0_y);
    // centre relative to each end
    s1_c0x_nxt  = W2'(in_s.circle_x) - W2'(in_s.base_x) - W2'(in_s.off0_x);
    s1_c0y_nxt  = W2'(in_s.circle_y) - W2'(in_s.base_y) - W2'(in_s.off0_y);
    s1_c1x_nxt  = W2'(in_s.circle_x) - W2'(in_s.base_x) - W2'(in_s.off1_x);
    s1_c1y_nxt  = W2'(in_s.circle_y) - W2'(in_s.base_y) - W2'(in_s.off1_y);
  end

  always_ff @(posedge clk) begin
    if (rd1) begin
      s1_cc_r   <= s1_cc_nxt;
      s1_seg_r  <= s1_seg_nxt;
      s1_rsum_r <= s1_rsum_nxt;
      s1_r_r    <= in_s.circle_radius;
      s1_dx_r   <= s1_dx_nxt;
      s1_dy_r   <= s1_dy_nxt;
      s1_ex_r   <= s1_ex_nxt;
      s1_ey_r   <= s1_ey_nxt;
      s1_c0x_r  <= s1_c0x_nxt;
      s1_c0y_r  <= s1_c0y_nxt;
      s1_c1x_r  <= s1_c1x_nxt;
      s1_c1y_r  <= s1_c1y_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: one rank of multipliers, all side by side
  // --------------------------------------------------------------------------
  logic signed [PX-1:0] sqx_full, sqy_full, ex2_full, ey2_full;
  logic signed [PQ-1:0] q0x_full, q0y_full, q1x_full, q1y_full;

  assign sqx_full = PX'(s1_dx_r) * PX'(s1_dx_r);
  assign sqy_full = PX'(s1_dy_r) * PX'(s1_dy_r);
  assign ex2_full = PX'(s1_ex_r) * PX'(s1_ex_r);
  assign ey2_full = PX'(s1_ey_r) * PX'(s1_ey_r);
  assign q0x_full = PQ'(s1_c0x_r) * PQ'(s1_c0x_r);
  assign q0y_full = PQ'(s1_c0y_r) * PQ'(s1_c0y_r);
  assign q1x_full = PQ'(s1_c1x_r) * PQ'(s1_c1x_r);
  assign q1y_full = PQ'(s1_c1y_r) * PQ'(s1_c1y_r);

  logic                           s2_cc_r, s2_seg_r;
  logic [PX-2:0]                  s2_sqx_r, s2_sqy_r;   // |d| <= 2^W
  logic [2*W-1:0]                 s2_ex2_r, s2_ey2_r;   // |e| < 2^W
  logic [PQ-3:0]                  s2_q0x_r, s2_q0y_r, s2_q1x_r, s2_q1y_r;
  logic [csc_pkg::RS2_BITS-1:0]   s2_rs2_r;
  logic [csc_pkg::RR_BITS-1:0]    s2_rr_r;
  logic signed [PC-1:0]           s2_cra_r, s2_crb_r;
  logic signed [PC-1:0]           s2_d0a_r, s2_d0b_r, s2_d1a_r, s2_d1b_r;

  always_ff @(posedge clk) begin
    if (rd2) begin
      s2_cc_r  <= s1_cc_r;
      s2_seg_r <= s1_seg_r;
      s2_sqx_r <= sqx_full[PX-2:0];
      s2_sqy_r <= sqy_full[PX-2:0];
      s2_ex2_r <= ex2_full[2*W-1:0];
      s2_ey2_r <= ey2_full[2*W-1:0];
      s2_q0x_r <= q0x_full[PQ-3:0];
      s2_q0y_r <= q0y_full[PQ-3:0];
      s2_q1x_r <= q1x_full[PQ-3:0];
      s2_q1y_r <= q1y_full[PQ-3:0];
      s2_rs2_r <= csc_pkg::RS2_BITS'(s1_rsum_r) * csc_pkg::RS2_BITS'(s1_rsum_r);
      s2_rr_r  <= csc_pkg::RR_BITS'(s1_r_r) * csc_pkg::RR_BITS'(s1_r_r);
      // cross product terms c0 x e
      s2_cra_r <= PC'(s1_c0x_r) * PC'(s1_ey_r);
      s2_crb_r <= PC'(s1_c0y_r) * PC'(s1_ex_r);
      // end angle terms c0 . e and c1 . e
      s2_d0a_r <= PC'(s1_c0x_r) * PC'(s1_ex_r);
      s2_d0b_r <= PC'(s1_c0y_r) * PC'(s1_ey_r);
      s2_d1a_r <= PC'(s1_c1x_r) * PC'(s1_ex_r);
      s2_d1b_r <= PC'(s1_c1y_r) * PC'(s1_ey_r);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: sums and the narrow compares
  // --------------------------------------------------------------------------
  logic signed [PD-1:0] cross_nxt, cross_abs, dot0_nxt, dot1_nxt;
  logic [LW-1:0]        l2_nxt;
  logic [DW-1:0]        d0_nxt, d1_nxt;
  logic [LW-1:0]        dcc_nxt;
  logic                 on0, on1, in0, in1;

  always_comb begin
    cross_nxt = PD'(s2_cra_r) - PD'(s2_crb_r);
    cross_abs = cross_nxt[PD-1] ? -cross_nxt : cross_nxt;
    dot0_nxt  = PD'(s2_d0a_r) + PD'(s2_d0b_r);
    dot1_nxt  = PD'(s2_d1a_r) + PD'(s2_d1b_r);
    l2_nxt    = LW'(s2_ex2_r) + LW'(s2_ey2_r);
    d0_nxt    = DW'(s2_q0x_r) + DW'(s2_q0y_r);
    d1_nxt    = DW'(s2_q1x_r) + DW'(s2_q1y_r);
    dcc_nxt   = LW'(s2_sqx_r) + LW'(s2_sqy_r);
    // foot of the perpendicular within the segment at each end
    on0       = !dot0_nxt[PD-1];
    on1       = dot1_nxt[PD-1] || (dot1_nxt == '0);
    // end strictly inside the circle
    in0       = d0_nxt < s2_rr_r;
    in1       = d1_nxt < s2_rr_r;
  end

  logic                         s3_cc_r, s3_seg_r, s3_hit_cc_r, s3_l2z_r;
  logic                         s3_near_r, s3_in0_r;
  logic [LW-1:0]                s3_ac_r, s3_l2_r;
  logic [csc_pkg::RR_BITS-1:0]  s3_rr_r;

  always_ff @(posedge clk) begin
    if (rd3) begin
      s3_cc_r     <= s2_cc_r;
      s3_seg_r    <= s2_seg_r;
      s3_hit_cc_r <= dcc_nxt < s2_rs2_r;
      s3_l2z_r    <= l2_nxt == '0;
      s3_near_r   <= (on0 && on1) || in0 || in1;
      s3_in0_r    <= in0;
      s3_ac_r     <= cross_abs[LW-1:0];
      s3_l2_r     <= l2_nxt;
      s3_rr_r     <= s2_rr_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: cross^2 and r^2 * L^2 split into half-width partial products
  // --------------------------------------------------------------------------
  logic [H-1:0] ac_hi, ac_lo, l2_hi, l2_lo;
  assign ac_hi = s3_ac_r[LW-1:H];
  assign ac_lo = s3_ac_r[H-1:0];
  assign l2_hi = s3_l2_r[LW-1:H];
  assign l2_lo = s3_l2_r[H-1:0];

  logic               s4_cc_r, s4_seg_r, s4_hit_cc_r, s4_l2z_r, s4_near_r, s4_in0_r;
  logic [LW-1:0]      s4_hh_r, s4_hl_r, s4_ll_r;
  logic [RRH-1:0]     s4_rrh_r, s4_rrl_r;

  always_ff @(posedge clk) begin
    if (rd4) begin
      s4_cc_r     <= s3_cc_r;
      s4_seg_r    <= s3_seg_r;
      s4_hit_cc_r <= s3_hit_cc_r;
      s4_l2z_r    <= s3_l2z_r;
      s4_near_r   <= s3_near_r;
      s4_in0_r    <= s3_in0_r;
      s4_hh_r     <= LW'(ac_hi) * LW'(ac_hi);
      s4_hl_r     <= LW'(ac_hi) * LW'(ac_lo);
      s4_ll_r     <= LW'(ac_lo) * LW'(ac_lo);
      s4_rrh_r    <= RRH'(s3_rr_r) * RRH'(l2_hi);
      s4_rrl_r    <= RRH'(s3_rr_r) * RRH'(l2_lo);
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: assemble the wide products, line distance test, final select
  // --------------------------------------------------------------------------
  logic [CW-1:0] cross2, rl2;
  logic          miss, hit_nxt;

  always_comb begin
    cross2  = (CW'(s4_hh_r) << (2 * H)) + (CW'(s4_hl_r) << (H + 1)) + CW'(s4_ll_r);
    rl2     = (CW'(s4_rrh_r) << H) + CW'(s4_rrl_r);
    // line farther than the radius
    miss    = rl2 < cross2;
    // zero-length segment is a point test on the first end
    if (s4_cc_r) begin
      hit_nxt = s4_hit_cc_r;
    end else if (s4_seg_r) begin
      hit_nxt = s4_l2z_r ? s4_in0_r : (s4_near_r && !miss);
    end else begin
      hit_nxt = 1'b0;
    end
  end

  logic out_hit_r;

  always_ff @(posedge clk) begin
    if (rd_out) begin
      out_hit_r <= hit_nxt;
    end
  end

  assign out_s.hit = out_hit_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic [2:0] occ;
  assign occ = 3'($countones({v1_r, v2_r, v3_r, v4_r, out_v_r}));

  // an input transfer with no output transfer adds exactly one item
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !out_xfer) |=> (occ == $past(occ) + 3'd1))
    else $error("item lost entering the pipeline");

  // an output transfer with no input transfer removes exactly one item
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_xfer && out_xfer) |=> (occ == $past(occ) - 3'd1))
    else $error("item lost or repeated inside the pipeline");

  // an item with no enabled test never reports a hit
  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && rd_out && !s4_cc_r && !s4_seg_r) |=> !out_hit_r)
    else $error("hit reported for a disabled or untested pair");

endmodule

// ----- tb/sv/tb_circle_segment_collision_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_segment_collision_test
// self-checking bench for the circle / circle and circle / segment overlap test
// ----------------------------------------------------------------------------
// A short table of hand-picked pairs runs first: disabled shapes, unused pair
// kinds, touching and concentric circles, zero-length segments, tangents and
// coordinate extremes. Random pairs follow, mostly well-formed tests with
// local, full-range or extreme coordinates, plus noise on kind and enables.
// Each accepted pair is scored by an exact integer model in the bench, and
// every hit coming back is compared in order against that prediction. Both
// sides of the valid/ready channels idle at random in several phases.
// ----------------------------------------------------------------------------
module tb_circle_segment_collision_test;

  localparam int COORD_BITS     = csc_pkg::COORD_BITS_DEF;
  localparam int RADIUS_BITS    = csc_pkg::RADIUS_BITS;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 20;     // latency is five stages, take some margin
  localparam int QUIET_LIMIT    = 5000;   // cycles without any transfer before giving up
  localparam int RANDOM_CHUNKS  = 8;
  localparam int CHUNK_PAIRS    = 204;

  // pair kinds and the both-enabled code
  localparam logic [1:0] ACT_CIRCLE_CIRCLE   = csc_pkg::ACT_CIRCLE_CIRCLE;
  localparam logic [1:0] ACT_CIRCLE_SEGMENT  = csc_pkg::ACT_CIRCLE_SEGMENT;
  localparam logic [1:0] ACT_SEGMENT_SEGMENT = csc_pkg::ACT_SEGMENT_SEGMENT;
  localparam logic [1:0] EN_BOTH             = csc_pkg::EN_BOTH;

  // pair kind with no meaning, scored like segment-segment
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // enable combinations other than both
  localparam logic [1:0] EN_NONE   = 2'b00;
  localparam logic [1:0] EN_FIRST  = 2'b01;
  localparam logic [1:0] EN_SECOND = 2'b10;

  // expected-hit column of the directed table
  localparam int HIT     = 1;
  localparam int MISS    = 0;
  localparam int PREDICT = -1;

  // coordinate styles for random pairs
  localparam int STYLE_LOCAL = 0;
  localparam int STYLE_FULL  = 1;
  localparam int STYLE_EDGE  = 2;

  typedef struct packed {
    logic [1:0]                   action;
    logic [1:0]                   enable_flags;
    logic signed [COORD_BITS-1:0] circle_x;
    logic signed [COORD_BITS-1:0] circle_y;
    logic [RADIUS_BITS-1:0]       circle_radius;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic [RADIUS_BITS-1:0]       other_radius;
    logic signed [COORD_BITS-1:0] off0_x;
    logic signed [COORD_BITS-1:0] off0_y;
    logic signed [COORD_BITS-1:0] off1_x;
    logic signed [COORD_BITS-1:0] off1_y;
  } pair_t;

  // wide enough for r^2 * L^2 and the squared cross product
  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst_n;

  csc_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  csc_out_if                           out_ch ();

  circle_segment_collision_test #(.COORD_BITS(COORD_BITS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  always #5 clk = ~clk;

  // hits still owed by the pipeline, oldest first
  bit    expected_hits[$];
  int    mismatch_count = 0;

  // idle rates in percent, changed per phase
  int    src_idle_pct = 0;
  int    snk_stall_pct = 0;

  // directed table, one row per pair
  pair_t directed_pairs[$];
  int    directed_want[$];

  // --------------------------------------------------------------------------
  // exact scoring of one pair
  // --------------------------------------------------------------------------

  // circle against segment p0-p1; all inputs are small enough for longint
  // except the two products compared in the line-distance test
  function automatic bit segment_hit(input longint cx, input longint cy,
                                     input longint r,
                                     input longint p0x, input longint p0y,
                                     input longint p1x, input longint p1y);
    longint ex, ey, c0x, c0y, c1x, c1y;
    longint rr, len2, crs, dot0, dot1;
    wide_t  rr_w, len2_w, cross_w;
    ex   = p1x - p0x;
    ey   = p1y - p0y;
    c0x  = cx - p0x;
    c0y  = cy - p0y;
    c1x  = cx - p1x;
    c1y  = cy - p1y;
    rr   = r * r;
    len2 = ex * ex + ey * ey;
    // zero-length segment degenerates to a point
    if (len2 == 0)
      return (c0x * c0x + c0y * c0y) < rr;
    // line too far from the centre: D^2 > r^2 L^2
    crs     = c0x * ey - c0y * ex;
    rr_w    = rr;
    len2_w  = len2;
    cross_w = crs;
    if (rr_w * len2_w < cross_w * cross_w)
      return 1'b0;
    // foot of the perpendicular between the ends
    dot0 = c0x * ex + c0y * ey;
    dot1 = c1x * (-ex) + c1y * (-ey);
    if (dot0 >= 0 && dot1 >= 0)
      return 1'b1;
    // otherwise one end has to sit strictly inside
    if (c0x * c0x + c0y * c0y < rr)
      return 1'b1;
    return (c1x * c1x + c1y * c1y) < rr;
  endfunction

  function automatic bit predict_hit(input pair_t p);
    longint cx, cy, r0, bx, by, r1, o0x, o0y, o1x, o1y;
    bit     hit;
    cx  = p.circle_x;
    cy  = p.circle_y;
    r0  = p.circle_radius;
    bx  = p.base_x;
    by  = p.base_y;
    r1  = p.other_radius;
    o0x = p.off0_x;
    o0y = p.off0_y;
    o1x = p.off1_x;
    o1y = p.off1_y;
    hit = 1'b0;
    if (p.enable_flags == EN_BOTH) begin
      if (p.action == ACT_CIRCLE_CIRCLE) begin
        hit = ((cx - bx) * (cx - bx) + (cy - by) * (cy - by)) < ((r0 + r1) * (r0 + r1));
      end else if (p.action == ACT_CIRCLE_SEGMENT) begin
        hit = segment_hit(cx, cy, r0, bx + o0x, by + o0y, bx + o1x, by + o1y);
      end
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------

  task automatic add_row(input int act, input int en, input int cx, input int cy,
                         input int r, input int bx, input int by, input int ro,
                         input int o0x, input int o0y, input int o1x, input int o1y,
                         input int want);
    pair_t p;
    p.action        = act[1:0];
    p.enable_flags  = en[1:0];
    p.circle_x      = cx[COORD_BITS-1:0];
    p.circle_y      = cy[COORD_BITS-1:0];
    p.circle_radius = r[RADIUS_BITS-1:0];
    p.base_x        = bx[COORD_BITS-1:0];
    p.base_y        = by[COORD_BITS-1:0];
    p.other_radius  = ro[RADIUS_BITS-1:0];
    p.off0_x        = o0x[COORD_BITS-1:0];
    p.off0_y        = o0y[COORD_BITS-1:0];
    p.off1_x        = o1x[COORD_BITS-1:0];
    p.off1_y        = o1y[COORD_BITS-1:0];
    directed_pairs.push_back(p);
    directed_want.push_back(want);
  endtask

  function automatic int pick_coord(input int style, input int anchor);
    int v;
    case (style)
      STYLE_LOCAL: v = anchor + int'($urandom_range(0, 600)) - 300;
      STYLE_FULL:  v = int'($urandom_range(0, 65535)) - 32768;
      default: begin
        case ($urandom_range(0, 6))
          0:       v = -32768;
          1:       v = -32767;
          2:       v = -1;
          3:       v = 0;
          4:       v = 1;
          5:       v = 32766;
          default: v = 32767;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int pick_radius(input int style);
    int v;
    case (style)
      STYLE_LOCAL: v = int'($urandom_range(0, 300));
      STYLE_FULL:  v = int'($urandom_range(0, 32767));
      default: begin
        case ($urandom_range(0, 5))
          0:       v = 0;
          1:       v = 1;
          2:       v = 16383;
          3:       v = 16384;
          4:       v = 32766;
          default: v = 32767;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    roll, style, anchor;
    roll = int'($urandom_range(0, 99));
    style = (roll < 60) ? STYLE_LOCAL : (roll < 85) ? STYLE_FULL : STYLE_EDGE;
    anchor = int'($urandom_range(0, 64000)) - 32000;
    // mostly real tests with both shapes on, some noise on kind and enables
    if ($urandom_range(0, 99) < 85) begin
      p.enable_flags = EN_BOTH;
      p.action = $urandom_range(0, 1) ? ACT_CIRCLE_SEGMENT : ACT_CIRCLE_CIRCLE;
    end else begin
      p.enable_flags = 2'($urandom_range(0, 3));
      p.action       = 2'($urandom_range(0, 3));
    end
    p.circle_x      = 16'(pick_coord(style, anchor));
    p.circle_y      = 16'(pick_coord(style, anchor));
    p.circle_radius = 15'(pick_radius(style));
    p.base_x        = 16'(pick_coord(style, anchor));
    p.base_y        = 16'(pick_coord(style, anchor));
    p.other_radius  = 15'(pick_radius(style));
    // offsets are relative, so local ones stay around zero
    p.off0_x        = 16'(pick_coord(style, 0));
    p.off0_y        = 16'(pick_coord(style, 0));
    p.off1_x        = 16'(pick_coord(style, 0));
    p.off1_y        = 16'(pick_coord(style, 0));
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // pair channel driver
  // --------------------------------------------------------------------------

  task automatic put_pair(input pair_t p);
    in_ch.action        <= p.action;
    in_ch.enable_flags  <= p.enable_flags;
    in_ch.circle_x      <= p.circle_x;
    in_ch.circle_y      <= p.circle_y;
    in_ch.circle_radius <= p.circle_radius;
    in_ch.base_x        <= p.base_x;
    in_ch.base_y        <= p.base_y;
    in_ch.other_radius  <= p.other_radius;
    in_ch.off0_x        <= p.off0_x;
    in_ch.off0_y        <= p.off0_y;
    in_ch.off1_x        <= p.off1_x;
    in_ch.off1_y        <= p.off1_y;
  endtask

  // called just after a rising edge; returns in the step of the transfer
  task automatic send_pair(input pair_t p, input int want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    put_pair(p);
    in_ch.valid <= 1'b1;
    // ready is read before this edge's updates land, as the block saw it
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_hits.push_back((want == PREDICT) ? predict_hit(p) : want[0]);
  endtask

  // --------------------------------------------------------------------------
  // result side: random back-pressure and in-order checking
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    bit want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_hits.size() == 0) begin
        $error("hit: expected none, got %0b", out_ch.hit);
        mismatch_count++;
      end else begin
        want = expected_hits.pop_front();
        if (out_ch.hit !== want) begin
          $error("hit: expected %0b, got %0b", want, out_ch.hit);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("circle_segment_collision_test: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    out_ch.ready = 1'b0;
    put_pair('0);

    // act, en, cx, cy, r, bx, by, ro, o0x, o0y, o1x, o1y, expected
    // disabled shapes score as a miss even when concentric
    add_row(ACT_CIRCLE_CIRCLE, EN_SECOND, 0, 0, 10, 0, 0, 10, 0, 0, 0, 0, MISS);
    add_row(ACT_CIRCLE_CIRCLE, EN_FIRST, 0, 0, 10, 0, 0, 10, 0, 0, 0, 0, MISS);
    add_row(ACT_CIRCLE_SEGMENT, EN_NONE, 0, 0, 10, 0, 0, 0, -5, 0, 5, 0, MISS);
    // segment-segment and the unused kind never hit
    add_row(ACT_SEGMENT_SEGMENT, EN_BOTH, 0, 0, 10, 0, 0, 10, -5, 0, 5, 0, MISS);
    add_row(ACT_UNUSED, EN_BOTH, 0, 0, 10, 0, 0, 10, -5, 0, 5, 0, MISS);
    // circle-circle: concentric, touching, zero radii, extremes
    add_row(ACT_CIRCLE_CIRCLE, EN_BOTH, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0, HIT);
    add_row(ACT_CIRCLE_CIRCLE, EN_BOTH, 0, 0, 1, 2, 0, 1, 0, 0, 0, 0, MISS);
    add_row(ACT_CIRCLE_CIRCLE, EN_BOTH, 7, -7, 0, 7, -7, 0, 0, 0, 0, 0, MISS);
    add_row(ACT_CIRCLE_CIRCLE, EN_BOTH, 32767, -32768, 32767, 32767, -32768, 32767,
            0, 0, 0, 0, HIT);
    add_row(ACT_CIRCLE_CIRCLE, EN_BOTH, -32768, -32768, 32767, 32767, 32767, 32767,
            0, 0, 0, 0, MISS);
    // offsets are don't-care for circle-circle
    add_row(ACT_CIRCLE_CIRCLE, EN_BOTH, 100, 100, 50, 160, 100, 20,
            -32768, 32767, 32767, -32768, PREDICT);
    // zero-length segment acts as a point
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, HIT);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MISS);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 6, 0, 0, 0, 5, -3, 5, -3, PREDICT);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 5, 0, 0, 0, 5, -3, 5, -3, PREDICT);
    // segment through the centre, line too far, beyond the ends, end inside
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 5, 0, 0, 0, -10, 0, 10, 0, HIT);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 5, 0, 0, 0, -10, 100, 10, 100, MISS);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 5, 0, 0, 0, 20, 0, 30, 0, MISS);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 5, 0, 0, 0, 3, 0, 30, 0, HIT);
    // tangent line, and other_radius ignored for segments
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 5, 0, 0, 32767, -10, 5, 10, 5, PREDICT);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 0, 0, 5, 0, 0, 32767, -10, 6, 10, 6, PREDICT);
    // coordinate extremes: ends well outside the 16-bit range
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, 32767, 32767, 32767, -32768, -32768, 0,
            -32768, -32768, 32767, 32767, PREDICT);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, -32768, 32767, 32767, 32767, 32767, 32767,
            32767, 32767, 32767, -32768, PREDICT);
    add_row(ACT_CIRCLE_SEGMENT, EN_BOTH, -32768, -32768, 32767, 32767, -32768, 0,
            32767, -32768, -32768, 32767, PREDICT);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    foreach (directed_pairs[i]) send_pair(directed_pairs[i], directed_want[i]);

    // random pairs, idling phases rotating: none, sender, receiver, both
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      case (chunk % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      for (int n = 0; n < CHUNK_PAIRS; n++) send_pair(random_pair(), PREDICT);
    end
    in_ch.valid <= 1'b0;

    // let the pipeline drain, then watch a little longer for stray results
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("circle_segment_collision_test: match");
    end else begin
      $display("circle_segment_collision_test: mismatch");
    end
    $finish;
  end

endmodule
